FILE: rtl/core/zscii_text_packer_unit_defines.svh
// Assertion macros used by the text packer back end (zpk_back).
`ifndef ZSCII_TEXT_PACKER_UNIT_DEFINES_SVH
`define ZSCII_TEXT_PACKER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define ZPK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ZPK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/zpk_pkg.sv
`default_nettype none

package zpk_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [4:0] ZC_SPACE       = 5'd0;
  localparam logic [4:0] ZC_SHIFT_UPPER = 5'd4;
  localparam logic [4:0] ZC_SHIFT_PUNCT = 5'd5;
  localparam logic [4:0] ZC_PAD         = 5'd5;
  localparam logic [4:0] ZC_ESCAPE      = 5'd6;
  localparam logic [4:0] ZC_COLUMN_BASE = 5'd6;

  localparam logic [7:0] CH_NEWLINE  = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

  localparam logic [15:0] END_MARK = 16'h8000;

  // One classified item: the z-chars it expands to, first in z[0].
  typedef struct packed {
    logic            op;
    logic [2:0]      n;
    logic [3:0][4:0] z;
  } zpk_cmd_t;

  // Column of a code in the punctuation row, or zero when it has none there.
  function automatic logic [4:0] a2_column(input logic [7:0] code);
    logic [4:0] col;
    col = 5'd0;
    unique case (code) inside
      CH_NEWLINE:                col = 5'd1;
      [CH_DIGIT_0:CH_DIGIT_9]:   col = 5'(code - CH_DIGIT_0) + 5'd2;
      8'h2E:                     col = 5'd12;
      8'h2C:                     col = 5'd13;
      8'h21:                     col = 5'd14;
      CH_QUESTION:               col = 5'd15;
      8'h5F:                     col = 5'd16;
      8'h23:                     col = 5'd17;
      8'h27:                     col = 5'd18;
      8'h22:                     col = 5'd19;
      8'h2F:                     col = 5'd20;
      8'h5C:                     col = 5'd21;
      8'h2D:                     col = 5'd22;
      8'h3A:                     col = 5'd23;
      8'h28:                     col = 5'd24;
      8'h29:                     col = 5'd25;
      default:                   col = 5'd0;
    endcase
    return col;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/zpk_front.sv
`default_nettype none

module zpk_front
  import zpk_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       opcode,
  input  wire logic [7:0] char_code,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output zpk_cmd_t        cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  zpk_cmd_t        slots [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   count;
  zpk_cmd_t        classified;
  logic [7:0]      code;
  logic [4:0]      col;
  logic            in_fire;
  logic            out_fire;

  // Expand the character into its z-char sequence; a finish item carries none.
  always_comb begin
    code = (char_code == 8'd0) ? CH_QUESTION : char_code;
    col  = a2_column(code);
    classified    = '0;
    classified.op = opcode;
    if (opcode == OP_FINISH) begin
      classified.n = 3'd0;
    end else if (code == CH_SPACE) begin
      classified.n    = 3'd1;
      classified.z[0] = ZC_SPACE;
    end else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
      classified.n    = 3'd1;
      classified.z[0] = ZC_COLUMN_BASE + 5'(code - CH_LOWER_A);
    end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
      classified.n    = 3'd2;
      classified.z[0] = ZC_SHIFT_UPPER;
      classified.z[1] = ZC_COLUMN_BASE + 5'(code - CH_UPPER_A);
    end else if (col != 5'd0) begin
      classified.n    = 3'd2;
      classified.z[0] = ZC_SHIFT_PUNCT;
      classified.z[1] = ZC_COLUMN_BASE + col;
    end else begin
      classified.n    = 3'd4;
      classified.z[0] = ZC_SHIFT_PUNCT;
      classified.z[1] = ZC_ESCAPE;
      classified.z[2] = {2'b00, code[7:5]};
      classified.z[3] = code[4:0];
    end
  end

  assign full      = (count == CW'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rp];
  assign in_fire   = push && !full;
  assign out_fire  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slots[wp] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (in_fire) begin
        wp <= (wp == LAST) ? '0 : wp + 1'b1;
      end
      if (out_fire) begin
        rp <= (rp == LAST) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(in_fire) - CW'(out_fire);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/zpk_back.sv
`default_nettype none

`include "zscii_text_packer_unit_defines.svh"

module zpk_back
  import zpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire zpk_cmd_t    cmd,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      packed_word,
  output logic             string_end,
  output logic             last_of_item
);

  typedef struct packed {
    logic [15:0] word;
    logic        string_end;
    logic        last;
  } result_t;

  // Packing state.
  logic [14:0] partial;
  logic [1:0]  pend;
  logic [14:0] held;
  logic        held_valid;
  logic [14:0] partial_next;
  logic [1:0]  pend_next;
  logic [14:0] held_next;
  logic        held_valid_next;

  // Words produced by the current command.
  logic [15:0] res_word [2];
  logic        res_end  [2];
  logic [1:0]  nres;

  // Result buffer.
  result_t     res_buf [4];
  logic [1:0]  res_wp;
  logic [1:0]  res_rp;
  logic [2:0]  res_count;

  logic        cmd_fire;
  logic        pop_fire;
  logic [2:0]  seq_n;
  logic [3:0][4:0] seq_z;

  always_comb begin
    partial_next    = partial;
    pend_next       = pend;
    held_next       = held;
    held_valid_next = held_valid;
    nres            = 2'd0;
    res_word[0]     = '0;
    res_word[1]     = '0;
    res_end[0]      = 1'b0;
    res_end[1]      = 1'b0;
    seq_z           = cmd.z;
    seq_n           = cmd.n;

    // A finish pads the open word; an empty string becomes one padded word.
    if (cmd.op == OP_FINISH) begin
      seq_z = {4{ZC_PAD}};
      case (pend)
        2'd1:    seq_n = 3'd2;
        2'd2:    seq_n = 3'd1;
        default: seq_n = held_valid ? 3'd0 : 3'd3;
      endcase
    end

    for (int i = 0; i < 4; i++) begin
      if (3'(i) < seq_n) begin
        case (pend_next)
          2'd0:    partial_next[14:10] = seq_z[i];
          2'd1:    partial_next[9:5]   = seq_z[i];
          default: partial_next[4:0]   = seq_z[i];
        endcase
        if (pend_next == 2'd2) begin
          // A completed word pushes out the one held before it.
          if (held_valid_next) begin
            res_word[nres[0]] = {1'b0, held_next};
            res_end[nres[0]]  = 1'b0;
            nres              = nres + 2'd1;
          end
          held_next       = partial_next;
          held_valid_next = 1'b1;
          partial_next    = '0;
          pend_next       = 2'd0;
        end else begin
          pend_next = pend_next + 2'd1;
        end
      end
    end

    if (cmd.op == OP_FINISH) begin
      res_word[nres[0]] = {1'b0, held_next} | END_MARK;
      res_end[nres[0]]  = 1'b1;
      nres              = nres + 2'd1;
      partial_next      = '0;
      pend_next         = 2'd0;
      held_next         = '0;
      held_valid_next   = 1'b0;
    end
  end

  // A command needs room for the two words it may produce.
  assign cmd_ready    = (res_count <= 3'd2);
  assign cmd_fire     = cmd_valid && cmd_ready;
  assign empty        = (res_count == 3'd0);
  assign pop_fire     = pop && !empty;
  assign packed_word  = res_buf[res_rp].word;
  assign string_end   = res_buf[res_rp].string_end;
  assign last_of_item = res_buf[res_rp].last;

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < nres) begin
          res_buf[res_wp + 2'(k)] <= '{word:       res_word[k],
                                       string_end: res_end[k],
                                       last:       (2'(k) == nres - 2'd1)};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      pend       <= 2'd0;
      held       <= '0;
      held_valid <= 1'b0;
      res_wp     <= '0;
      res_rp     <= '0;
      res_count  <= '0;
    end else begin
      if (cmd_fire) begin
        partial    <= partial_next;
        pend       <= pend_next;
        held       <= held_next;
        held_valid <= held_valid_next;
        res_wp     <= res_wp + nres;
      end
      if (pop_fire) begin
        res_rp <= res_rp + 2'd1;
      end
      res_count <= res_count + (cmd_fire ? {1'b0, nres} : 3'd0) - 3'(pop_fire);
    end
  end

  `ZPK_ASSERT(a_res_no_overflow, res_count <= 3'd4, "result buffer overflow")
  `ZPK_ASSERT(a_pend_in_range, pend != 2'd3, "pending z-char count out of range")
  `ZPK_ASSERT(a_finish_clears, (cmd_fire && cmd.op == OP_FINISH) |=> (pend == 2'd0 && !held_valid && partial == 15'd0), "finish left packing state behind")
  `ZPK_ASSERT_ALWAYS(a_reset_drains, rst |=> (res_count == 3'd0 && !held_valid), "reset did not clear the back end")

endmodule

`default_nettype wire

FILE: rtl/core/zscii_text_packer_unit.sv
`default_nettype none

// Packs ZSCII text into version 3 Z-machine text words, three 5-bit z-chars
// per word with bit 15 marking the final word of a string. Push append items
// (opcode 0, one character each) and a finish item (opcode 1) per string; the
// words come out of the result queue in order, each tagged with string_end and
// with last_of_item on the final word caused by an input item. An item is
// taken whenever the command queue (CMD_DEPTH entries) has room, and the
// packer consumes one command per cycle while its four-entry result buffer
// has at least two free slots. Results leave one per cycle while popped; an
// item produces zero, one or two words, all through the single result port.
// The first result passes through the command queue and the result buffer
// registers before it is visible.
module zscii_text_packer_unit
  import zpk_pkg::*;
#(
  parameter int CMD_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode,
  input  wire logic [7:0]  char_code,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      packed_word,
  output logic             string_end,
  output logic             last_of_item
);

  logic     cmd_valid;
  logic     cmd_ready;
  zpk_cmd_t cmd;

  zpk_front #(
    .DEPTH(CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .char_code (char_code),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  zpk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .empty        (empty),
    .pop          (pop),
    .packed_word  (packed_word),
    .string_end   (string_end),
    .last_of_item (last_of_item)
  );

endmodule

`default_nettype wire
